// File: hdl/oru_pkg.sv
// Shared types and constants of the occupancy ray update unit.
`timescale 1ns / 1ps
`default_nettype none
package oru_pkg;

	localparam int CoordW = 12;
	localparam int ErrW = 14;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [ErrW-1:0] err_t;
	typedef logic signed [15:0] q78_t;
	typedef logic [7:0] count_t;
	typedef logic [1:0] status_t;
	typedef logic [2:0] reg_index_t;

	localparam status_t StatusApplied = 2'd0;
	localparam status_t StatusSkipped = 2'd1;
	localparam status_t StatusRead = 2'd2;

	localparam reg_index_t RegSensorX = 3'd0;
	localparam reg_index_t RegSensorY = 3'd1;
	localparam reg_index_t RegHitDelta = 3'd2;
	localparam reg_index_t RegMissDelta = 3'd3;
	localparam reg_index_t RegClampLow = 3'd4;
	localparam reg_index_t RegClampHigh = 3'd5;

	localparam q78_t OneQ78 = 16'sd256;

	typedef struct packed {
		logic start;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} ray_req_t;

	typedef struct packed {
		logic valid;
		logic last;
		coord_t x;
		coord_t y;
	} ray_cell_t;

endpackage
`default_nettype wire

// File: hdl/oru_sat_add.sv
// Saturating Q7.8 adder shared by every cell update.
`timescale 1ns / 1ps
`default_nettype none
module oru_sat_add (
	input wire oru_pkg::q78_t cur_value,
	input wire oru_pkg::q78_t delta,
	input wire oru_pkg::q78_t clamp_low,
	input wire oru_pkg::q78_t clamp_high,
	output oru_pkg::q78_t sum
);
	import oru_pkg::*;

	logic signed [16:0] wide;

	always_comb begin
		wide = 17'(cur_value) + 17'(delta);
		priority if (wide < 17'(clamp_low)) begin
			sum = clamp_low;
		end else if (wide > 17'(clamp_high)) begin
			sum = clamp_high;
		end else begin
			sum = q78_t'(wide);
		end
	end

endmodule
`default_nettype wire

// File: hdl/oru_line_walker.sv
// Bresenham line stepper that emits one ray cell per cycle.
`timescale 1ns / 1ps
`default_nettype none
module oru_line_walker (
	input wire clk,
	input wire arst_n,
	input wire oru_pkg::ray_req_t req,
	output oru_pkg::ray_cell_t cur_cell,
	output logic busy
);
	import oru_pkg::*;

	coord_t cx_q;
	coord_t cy_q;
	coord_t ex_q;
	coord_t ey_q;
	err_t dx_q;
	err_t dy_q;
	err_t err_q;
	logic x_neg_q;
	logic y_neg_q;
	logic active_q;

	coord_t diff_x;
	coord_t diff_y;
	err_t abs_dx;
	err_t abs_dy;
	err_t e2;
	err_t err_next;
	logic step_x;
	logic step_y;
	logic at_end;

	always_comb begin
		diff_x = req.end_x - req.start_x;
		diff_y = req.end_y - req.start_y;
		abs_dx = (diff_x < 0) ? -err_t'(diff_x) : err_t'(diff_x);
		abs_dy = (diff_y < 0) ? -err_t'(diff_y) : err_t'(diff_y);
		at_end = (cx_q == ex_q) && (cy_q == ey_q);
		e2 = err_q <<< 1;
		step_x = (e2 >= dy_q);
		step_y = (e2 <= dx_q);
		err_next = err_q + (step_x ? dy_q : err_t'(0)) + (step_y ? dx_q : err_t'(0));
		cur_cell.valid = active_q;
		cur_cell.last = at_end;
		cur_cell.x = cx_q;
		cur_cell.y = cy_q;
		busy = active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (req.start) begin
			active_q <= 1'b1;
		end else if (active_q && at_end) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			cx_q <= req.start_x;
			cy_q <= req.start_y;
			ex_q <= req.end_x;
			ey_q <= req.end_y;
			dx_q <= abs_dx;
			dy_q <= -abs_dy;
			err_q <= abs_dx - abs_dy;
			x_neg_q <= !(req.start_x < req.end_x);
			y_neg_q <= !(req.start_y < req.end_y);
		end else if (active_q && !at_end) begin
			err_q <= err_next;
			if (step_x) begin
				cx_q <= x_neg_q ? cx_q - coord_t'(1) : cx_q + coord_t'(1);
			end
			if (step_y) begin
				cy_q <= y_neg_q ? cy_q - coord_t'(1) : cy_q + coord_t'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/oru_cell_mem.sv
// Log-odds cell memory with a zero-fill sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
module oru_cell_mem #(
	parameter int Depth = 16384,
	parameter int AddrW = 14
) (
	input wire clk,
	input wire arst_n,
	input wire [AddrW-1:0] rd_addr,
	output oru_pkg::q78_t rd_data,
	input wire wr_en,
	input wire [AddrW-1:0] wr_addr,
	input wire oru_pkg::q78_t wr_data,
	output logic clr_busy
);
	import oru_pkg::*;

	q78_t mem [Depth];
	logic [AddrW-1:0] clr_addr_q;
	logic clr_busy_q;

	logic we;
	logic [AddrW-1:0] waddr;
	q78_t wdata;

	always_comb begin
		clr_busy = clr_busy_q;
		we = clr_busy_q || wr_en;
		waddr = clr_busy_q ? clr_addr_q : wr_addr;
		wdata = clr_busy_q ? q78_t'(0) : wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AddrW'(Depth - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// File: hdl/occupancy_ray_update_unit.sv
// Top level of the occupancy ray update unit: control, registers and result stage.
// An in-grid read passes ST_READ, then ST_FINISH; a skipped update or an out-of-grid read goes to ST_FINISH.
// A ray update of N line cells (longer axis span plus one) steps each cell through the line stepper,
// the registered read of the cell memory and the s1 stage to the memory's separate write port.
// One item at a time; with no output stall the unit is back in ST_IDLE as the result is registered.
// After reset a zero-fill sweep of all GRID_W * GRID_H cells runs before input is taken.
`timescale 1ns / 1ps
`default_nettype none
module occupancy_ray_update_unit #(
	parameter int GRID_W = 128,
	parameter int GRID_H = 128
) (
	input wire clk,
	input wire arst_n,
	input wire s_axis_tvalid,
	output logic s_axis_tready,
	input wire [23:0] s_axis_tdata, // x_coord[9:0], y_coord[19:10], zero pad
	input wire [0:0] s_axis_tuser, // action
	output logic m_axis_tvalid,
	input wire m_axis_tready,
	output logic [31:0] m_axis_tdata, // cell_value, occupied, free, cells_updated, zero pad
	output logic [1:0] m_axis_tuser, // status
	input wire cfg_valid,
	output logic cfg_ready,
	input wire oru_pkg::reg_index_t cfg_index,
	input wire [15:0] cfg_data
);
	import oru_pkg::*;

	localparam int Depth = GRID_W * GRID_H;
	localparam int AddrW = $clog2(Depth);
	localparam int XW = $clog2(GRID_W);
	localparam int YW = $clog2(GRID_H);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RAY,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [6:0] sensor_x_q;
	logic [6:0] sensor_y_q;
	q78_t hit_delta_q;
	q78_t miss_delta_q;
	q78_t clamp_low_q;
	q78_t clamp_high_q;

	status_t res_status_q;
	q78_t res_value_q;
	logic res_flags_q;
	count_t count_q;

	logic v_s1;
	logic inside_s1;
	logic last_s1;
	logic [AddrW-1:0] addr_s1;

	logic in_accept;
	coord_t in_x;
	coord_t in_y;
	logic in_inside;
	logic in_read;

	ray_req_t walk_req;
	ray_cell_t walk_cell;
	logic walk_busy;

	logic [AddrW-1:0] rd_addr;
	q78_t rd_data;
	logic clr_busy;
	logic mem_wr_en;
	q78_t upd_sum;
	q78_t upd_delta;
	logic out_free;

	function automatic logic in_grid(input coord_t x, input coord_t y);
		return (x >= coord_t'(0)) && (x < coord_t'(GRID_W)) &&
			(y >= coord_t'(0)) && (y < coord_t'(GRID_H));
	endfunction

	function automatic logic [AddrW-1:0] cell_addr(input coord_t x, input coord_t y);
		return AddrW'(y[YW-1:0]) * AddrW'(GRID_W) + AddrW'(x[XW-1:0]);
	endfunction

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE) && !clr_busy;
		cfg_ready = 1'b1;
		in_accept = s_axis_tvalid && s_axis_tready;
		in_x = coord_t'($signed(s_axis_tdata[9:0]));
		in_y = coord_t'($signed(s_axis_tdata[19:10]));
		in_inside = in_grid(in_x, in_y);
		in_read = s_axis_tuser[0];
		walk_req.start = in_accept && !in_read && in_inside;
		walk_req.start_x = coord_t'($signed({5'd0, sensor_x_q}));
		walk_req.start_y = coord_t'($signed({5'd0, sensor_y_q}));
		walk_req.end_x = in_x;
		walk_req.end_y = in_y;
		rd_addr = (state_q == ST_RAY) ? cell_addr(walk_cell.x, walk_cell.y)
			: cell_addr(in_x, in_y);
		upd_delta = last_s1 ? hit_delta_q : miss_delta_q;
		mem_wr_en = v_s1 && inside_s1;
		out_free = !m_axis_tvalid || m_axis_tready;
	end

	oru_line_walker u_walker (
		.clk (clk),
		.arst_n (arst_n),
		.req (walk_req),
		.cur_cell (walk_cell),
		.busy (walk_busy)
	);

	oru_cell_mem #(
		.Depth (Depth),
		.AddrW (AddrW)
	) u_mem (
		.clk (clk),
		.arst_n (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en (mem_wr_en),
		.wr_addr (addr_s1),
		.wr_data (upd_sum),
		.clr_busy (clr_busy)
	);

	oru_sat_add u_sat (
		.cur_value (rd_data),
		.delta (upd_delta),
		.clamp_low (clamp_low_q),
		.clamp_high (clamp_high_q),
		.sum (upd_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_x_q <= 7'd64;
			sensor_y_q <= 7'd64;
			hit_delta_q <= 16'sd218;
			miss_delta_q <= -16'sd102;
			clamp_low_q <= -16'sd512;
			clamp_high_q <= 16'sd896;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegSensorX: sensor_x_q <= cfg_data[6:0];
				RegSensorY: sensor_y_q <= cfg_data[6:0];
				RegHitDelta: hit_delta_q <= q78_t'(cfg_data);
				RegMissDelta: miss_delta_q <= q78_t'(cfg_data);
				RegClampLow: clamp_low_q <= q78_t'(cfg_data);
				RegClampHigh: clamp_high_q <= q78_t'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= walk_cell.valid && (state_q == ST_RAY);
		end
	end

	always_ff @(posedge clk) begin
		inside_s1 <= in_grid(walk_cell.x, walk_cell.y);
		last_s1 <= walk_cell.last;
		addr_s1 <= cell_addr(walk_cell.x, walk_cell.y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			m_axis_tuser <= StatusApplied;
			res_status_q <= StatusApplied;
			res_value_q <= '0;
			res_flags_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && (state_q != ST_FINISH)) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						count_q <= '0;
						res_value_q <= '0;
						res_flags_q <= in_inside;
						priority if (in_read) begin
							res_status_q <= StatusRead;
							state_q <= in_inside ? ST_READ : ST_FINISH;
						end else if (!in_inside) begin
							res_status_q <= StatusSkipped;
							state_q <= ST_FINISH;
						end else begin
							res_status_q <= StatusApplied;
							state_q <= ST_RAY;
						end
					end
				end
				ST_READ: begin
					res_value_q <= rd_data;
					state_q <= ST_FINISH;
				end
				ST_RAY: begin
					if (v_s1) begin
						if (inside_s1 && (count_q != 8'hFF)) begin
							count_q <= count_q + 1'b1;
						end
						if (last_s1) begin
							res_value_q <= upd_sum;
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tuser <= res_status_q;
						m_axis_tdata <= {6'd0, count_q,
							res_flags_q && (res_value_q < 0),
							res_flags_q && (res_value_q > OneQ78),
							res_value_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_walk_in_ray: assert property (@(posedge clk) disable iff (!arst_n)
		walk_busy |-> (state_q == ST_RAY))
		else $error("line stepper active outside ray state");

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> !clr_busy)
		else $error("cell update during clear sweep");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == StatusSkipped)) |-> (m_axis_tdata == '0))
		else $error("skipped update carries data");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second item taken while busy");

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench of the occupancy ray update unit with a cell grid predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import oru_pkg::*;

	localparam int GridW = 128;
	localparam int GridH = 128;
	localparam int StallLimit = 60000;
	localparam int DrainCycles = 200;
	localparam logic ActRay = 1'b0;
	localparam logic ActRead = 1'b1;

	typedef struct packed {
		status_t status;
		q78_t value;
		logic occupied;
		logic is_free;
		count_t updated;
	} cell_report_t;

	typedef struct packed {
		logic action;
		logic signed [9:0] x;
		logic signed [9:0] y;
		logic fixed;
		cell_report_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	reg_index_t cfg_index = RegSensorX;
	logic [15:0] cfg_data = '0;

	q78_t grid_cells [GridW*GridH];
	int sensor_x = 64;
	int sensor_y = 64;
	int hit_delta = 218;
	int miss_delta = -102;
	int clamp_low = -512;
	int clamp_high = 896;

	cell_report_t expected_reports [$];
	stim_row_t directed_rows [$];
	logic item_fixed = 1'b0;
	cell_report_t item_fixed_report = '0;
	cell_report_t got_report;
	cell_report_t want_report;
	int mismatches = 0;
	int stalled_cycles = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	occupancy_ray_update_unit #(
		.GRID_W(GridW),
		.GRID_H(GridH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int nudge_cell(int x, int y, int delta);
		int v;
		if (x < 0 || x >= GridW || y < 0 || y >= GridH) begin
			return 0;
		end
		v = int'(grid_cells[y*GridW + x]) + delta;
		if (v < clamp_low) begin
			v = clamp_low;
		end else if (v > clamp_high) begin
			v = clamp_high;
		end
		grid_cells[y*GridW + x] = q78_t'(v);
		return 1;
	endfunction

	function automatic cell_report_t predict_report(logic action, logic signed [9:0] x_in,
			logic signed [9:0] y_in);
		int ex, ey, cx, cy, dx, dy, sx, sy, err, e2, count;
		bit in_range;
		cell_report_t r;
		ex = int'(x_in);
		ey = int'(y_in);
		count = 0;
		r = '0;
		in_range = ex >= 0 && ex < GridW && ey >= 0 && ey < GridH;
		if (action == ActRead) begin
			r.status = StatusRead;
			if (in_range) begin
				r.value = grid_cells[ey*GridW + ex];
			end
		end else if (!in_range) begin
			r.status = StatusSkipped;
		end else begin
			r.status = StatusApplied;
			cx = sensor_x;
			cy = sensor_y;
			dx = ex > cx ? ex - cx : cx - ex;
			dy = -(ey > cy ? ey - cy : cy - ey);
			sx = cx < ex ? 1 : -1;
			sy = cy < ey ? 1 : -1;
			err = dx + dy;
			while (cx != ex || cy != ey) begin
				e2 = 2 * err;
				count += nudge_cell(cx, cy, miss_delta);
				if (e2 >= dy) begin
					err += dy;
					cx += sx;
				end
				if (e2 <= dx) begin
					err += dx;
					cy += sy;
				end
			end
			count += nudge_cell(ex, ey, hit_delta);
			r.value = grid_cells[ey*GridW + ex];
		end
		r.occupied = r.status != StatusSkipped && in_range && r.value > OneQ78;
		r.is_free = r.status != StatusSkipped && in_range && r.value < 0;
		r.updated = count > 255 ? 8'd255 : count_t'(count);
		return r;
	endfunction

	function automatic void apply_setting(reg_index_t idx, logic [15:0] data);
		case (idx)
			RegSensorX: sensor_x = int'(data[6:0]);
			RegSensorY: sensor_y = int'(data[6:0]);
			RegHitDelta: hit_delta = int'(signed'(data));
			RegMissDelta: miss_delta = int'(signed'(data));
			RegClampLow: clamp_low = int'(signed'(data));
			RegClampHigh: clamp_high = int'(signed'(data));
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_report.status = m_axis_tuser;
				got_report.value = m_axis_tdata[15:0];
				got_report.occupied = m_axis_tdata[16];
				got_report.is_free = m_axis_tdata[17];
				got_report.updated = m_axis_tdata[25:18];
				if (expected_reports.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, got status %0d value %0d occ %0d free %0d cnt %0d",
						$time, got_report.status, got_report.value, got_report.occupied,
						got_report.is_free, got_report.updated);
				end else begin
					want_report = expected_reports.pop_front();
					if (got_report !== want_report) begin
						mismatches++;
						$display("%0t: expected status %0d value %0d occ %0d free %0d cnt %0d",
							$time, want_report.status, want_report.value, want_report.occupied,
							want_report.is_free, want_report.updated);
						$display("%0t: actual   status %0d value %0d occ %0d free %0d cnt %0d",
							$time, got_report.status, got_report.value, got_report.occupied,
							got_report.is_free, got_report.updated);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want_report = predict_report(s_axis_tuser[0], s_axis_tdata[9:0],
					s_axis_tdata[19:10]);
				expected_reports.push_back(item_fixed ? item_fixed_report : want_report);
			end
			if (cfg_valid && cfg_ready) begin
				apply_setting(cfg_index, cfg_data);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= StallLimit) begin
			$display("%0t: no transaction for %0d cycles", $time, stalled_cycles);
			$display("occupancy_ray_update_unit test failed");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= $urandom_range(0, 99) >= sink_stall_pct;
	end

	function automatic void add_row(logic act, int x, int y, logic fixed, status_t st, int val,
			logic occ, logic fr, int cnt);
		stim_row_t r;
		r.action = act;
		r.x = x[9:0];
		r.y = y[9:0];
		r.fixed = fixed;
		r.want.status = st;
		r.want.value = val[15:0];
		r.want.occupied = occ;
		r.want.is_free = fr;
		r.want.updated = cnt[7:0];
		directed_rows.push_back(r);
	endfunction

	function automatic int near_sensor(int c);
		int v;
		v = c + int'($urandom_range(0, 16)) - 8;
		if (v < 0) begin
			v = 0;
		end else if (v > 127) begin
			v = 127;
		end
		return v;
	endfunction

	task automatic set_idling(int mode);
		case (mode)
			1: begin
				src_idle_pct = 81;
				sink_stall_pct = 0;
			end
			2: begin
				src_idle_pct = 0;
				sink_stall_pct = 81;
			end
			3: begin
				src_idle_pct = 14;
				sink_stall_pct = 14;
			end
			default: begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
		endcase
	endtask

	task automatic issue_item(stim_row_t r);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		item_fixed = r.fixed;
		item_fixed_report = r.want;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, r.y, r.x};
		s_axis_tuser <= r.action;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_reports();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_reports.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_setting(reg_index_t idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(int sx, int sy, int hit, int miss, int lo, int hi);
		logic [8:0] junk;
		junk = 9'($urandom_range(0, 511));
		write_setting(RegSensorX, {junk, sx[6:0]});
		junk = 9'($urandom_range(0, 511));
		write_setting(RegSensorY, {junk, sy[6:0]});
		write_setting(RegHitDelta, hit[15:0]);
		write_setting(RegMissDelta, miss[15:0]);
		write_setting(RegClampLow, lo[15:0]);
		write_setting(RegClampHigh, hi[15:0]);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_items(int n);
		stim_row_t r;
		int pick;
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 149) begin
				drain_reports();
			end
			r = '0;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				r.action = ActRay;
				r.x = 10'($urandom_range(0, GridW - 1));
				r.y = 10'($urandom_range(0, GridH - 1));
			end else if (pick < 65) begin
				r.action = ActRay;
				r.x = 10'(near_sensor(sensor_x));
				r.y = 10'(near_sensor(sensor_y));
			end else if (pick < 80) begin
				r.action = ActRead;
				r.x = 10'($urandom_range(0, GridW - 1));
				r.y = 10'($urandom_range(0, GridH - 1));
			end else if (pick < 90) begin
				r.action = ActRead;
				r.x = 10'(near_sensor(sensor_x));
				r.y = 10'(near_sensor(sensor_y));
			end else begin
				r.action = 1'($urandom_range(0, 1));
				r.x = 10'($urandom_range(0, 1023));
				r.y = 10'($urandom_range(0, 1023));
			end
			issue_item(r);
		end
	endtask

	initial begin
		for (int i = 0; i < GridW*GridH; i++) begin
			grid_cells[i] = '0;
		end

		add_row(ActRead, 0, 0, 1'b1, StatusRead, 0, 0, 0, 0);
		add_row(ActRead, 127, 127, 1'b1, StatusRead, 0, 0, 0, 0);
		add_row(ActRead, -512, -512, 1'b1, StatusRead, 0, 0, 0, 0);
		add_row(ActRead, 511, 511, 1'b1, StatusRead, 0, 0, 0, 0);
		add_row(ActRead, 128, 0, 1'b1, StatusRead, 0, 0, 0, 0);
		add_row(ActRead, 0, -1, 1'b1, StatusRead, 0, 0, 0, 0);
		add_row(ActRay, -1, 5, 1'b1, StatusSkipped, 0, 0, 0, 0);
		add_row(ActRay, 511, -512, 1'b1, StatusSkipped, 0, 0, 0, 0);
		add_row(ActRay, 0, 128, 1'b1, StatusSkipped, 0, 0, 0, 0);
		add_row(ActRay, 64, 64, 1'b1, StatusApplied, 218, 0, 0, 1);
		add_row(ActRay, 64, 64, 1'b1, StatusApplied, 436, 1, 0, 1);
		add_row(ActRay, 0, 0, 1'b0, StatusApplied, 0, 0, 0, 0);
		add_row(ActRay, 127, 127, 1'b0, StatusApplied, 0, 0, 0, 0);
		add_row(ActRay, 127, 0, 1'b0, StatusApplied, 0, 0, 0, 0);
		add_row(ActRay, 0, 127, 1'b0, StatusApplied, 0, 0, 0, 0);
		add_row(ActRay, 64, 0, 1'b0, StatusApplied, 0, 0, 0, 0);
		add_row(ActRay, 127, 64, 1'b0, StatusApplied, 0, 0, 0, 0);
		add_row(ActRay, 10, 100, 1'b0, StatusApplied, 0, 0, 0, 0);
		add_row(ActRay, 10, 100, 1'b0, StatusApplied, 0, 0, 0, 0);
		add_row(ActRead, 63, 63, 1'b0, StatusRead, 0, 0, 0, 0);
		add_row(ActRead, 64, 64, 1'b0, StatusRead, 0, 0, 0, 0);
		add_row(ActRead, 32, 32, 1'b0, StatusRead, 0, 0, 0, 0);
		add_row(ActRead, 127, 64, 1'b0, StatusRead, 0, 0, 0, 0);
		add_row(ActRead, 10, 100, 1'b0, StatusRead, 0, 0, 0, 0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_idling(0);
		foreach (directed_rows[i]) begin
			issue_item(directed_rows[i]);
		end
		drain_reports();
		item_fixed = 1'b0;

		set_idling(1);
		random_items(230);
		for (int phase = 1; phase < 8; phase++) begin
			drain_reports();
			case (phase)
				1: load_settings(0, 0, 32767, -32768, -32768, 32767);
				2: load_settings(127, 127, -32768, 32767, -32768, 32767);
				3: load_settings(0, 127, 300, -50, 100, -100);
				4: load_settings(127, 0, 218, -102, -512, 896);
				5: load_settings($urandom_range(0, 127), $urandom_range(0, 127),
					int'($urandom_range(0, 800)) - 400, int'($urandom_range(0, 800)) - 400,
					-int'($urandom_range(0, 2000)), $urandom_range(0, 2000));
				6: load_settings($urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
				default: load_settings($urandom_range(0, 127), $urandom_range(0, 127),
					int'($urandom_range(0, 600)) - 100, -int'($urandom_range(0, 300)),
					-int'($urandom_range(100, 1000)), $urandom_range(100, 1000));
			endcase
			set_idling(phase % 4);
			random_items(230);
		end

		set_idling(0);
		drain_reports();
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("occupancy_ray_update_unit test passed");
		end else begin
			$display("occupancy_ray_update_unit test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
